// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the RTL of the sine source.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define DSS_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is active.
`define DSS_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/dss_pkg.sv =====
// ----------------------------------------------------------------------------
// dss_pkg
// Types and fixed constants of the delayed sine source.
// ----------------------------------------------------------------------------
package dss_pkg;

    localparam int DATA_W   = 32;
    localparam int CFG_IDX_W = 3;
    localparam int NUM_STAGES = 6;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_OFFSET = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BIAS         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_START_DELAY  = 3'd4;

    localparam logic [DATA_W-1:0] AMPLITUDE_RESET = 32'h0001_0000;

    // pi in unsigned Q60
    localparam logic [63:0] PI_Q60 = 64'd3622009729038561421;

    typedef struct packed {
        logic [DATA_W-1:0] amplitude;
        logic [DATA_W-1:0] phase_step;
        logic [DATA_W-1:0] phase_offset;
        logic [DATA_W-1:0] bias;
        logic [DATA_W-1:0] start_delay;
    } dss_cfg_t;

    // per-stage load enables
    typedef struct packed {
        logic diff_ld;
        logic mul_ld;
        logic phase_ld;
        logic rom_ld;
        logic scale_ld;
        logic out_ld;
    } dss_adv_t;

endpackage

// ===== rtl/dss_phase.sv =====
// ----------------------------------------------------------------------------
// dss_phase
// Delay compare, phase multiply and offset; yields ROM index and sign.
// ----------------------------------------------------------------------------
module dss_phase #(
    parameter int PHASE_BITS    = 32,
    parameter int ROM_ADDR_BITS = 10
) (
    input  logic                       clk,
    input  dss_pkg::dss_adv_t          adv,
    input  dss_pkg::dss_cfg_t          cfg,
    input  logic [dss_pkg::DATA_W-1:0] time_ticks,
    output logic [ROM_ADDR_BITS-1:0]   rom_idx,
    output logic                       negate,
    output logic                       pre_delay
);
    import dss_pkg::*;

    logic [DATA_W-1:0]        diff_reg;
    logic                     before1_reg;
    logic [PHASE_BITS-1:0]    prod_reg;
    logic                     before2_reg;
    logic [ROM_ADDR_BITS-1:0] idx_reg;
    logic                     neg_reg;
    logic                     before3_reg;

    logic [63:0]              mul_full;
    logic [63:0]              off_ext;
    logic [PHASE_BITS-1:0]    phase;
    logic [1:0]               quad;
    logic [ROM_ADDR_BITS-1:0] idx_raw;

    assign mul_full = {32'b0, diff_reg} * {32'b0, cfg.phase_step};
    assign off_ext  = {32'b0, cfg.phase_offset};
    assign phase    = prod_reg - off_ext[PHASE_BITS-1:0];
    assign quad     = phase[PHASE_BITS-1 -: 2];
    assign idx_raw  = phase[PHASE_BITS-3 -: ROM_ADDR_BITS];

    always_ff @(posedge clk)
    begin
        if (adv.diff_ld)
        begin
            diff_reg    <= time_ticks - cfg.start_delay;
            before1_reg <= (time_ticks < cfg.start_delay);
        end
        if (adv.mul_ld)
        begin
            prod_reg    <= mul_full[PHASE_BITS-1:0];
            before2_reg <= before1_reg;
        end
        if (adv.phase_ld)
        begin
            // odd quadrants run the quarter wave backward
            idx_reg     <= quad[0] ? ~idx_raw : idx_raw;
            neg_reg     <= quad[1];
            before3_reg <= before2_reg;
        end
    end

    assign rom_idx   = idx_reg;
    assign negate    = neg_reg;
    assign pre_delay = before3_reg;

endmodule

// ===== rtl/dss_rom.sv =====
// ----------------------------------------------------------------------------
// dss_rom
// Quarter-wave sine table, built at elaboration, registered read.
// ----------------------------------------------------------------------------
module dss_rom #(
    parameter int ROM_ADDR_BITS = 10,
    parameter int SINE_BITS     = 16
) (
    input  logic                     clk,
    input  dss_pkg::dss_adv_t        adv,
    input  logic [ROM_ADDR_BITS-1:0] rom_idx,
    input  logic                     negate_in,
    input  logic                     before_in,
    output logic [SINE_BITS-2:0]     mag,
    output logic                     negate,
    output logic                     pre_delay
);
    import dss_pkg::*;

    localparam int ROM_DEPTH = 1 << ROM_ADDR_BITS;
    localparam int MAG_W     = SINE_BITS - 1;
    localparam logic [63:0] SINE_PEAK = (64'd1 << MAG_W) - 64'd1;

    typedef logic [MAG_W-1:0] rom_t [ROM_DEPTH];

    // one Taylor term update without the divide: term * x^2, Q30
    function automatic logic [63:0] sq_step(input logic [63:0] term, input logic [63:0] x);
        logic [63:0] a;
        a = (term * x) >> 30;
        return (a * x) >> 30;
    endfunction

    // sine in unsigned Q30, eleven truncated terms
    function automatic logic [63:0] sine_q30(input logic [63:0] x);
        logic [63:0] sum;
        logic [63:0] t;
        sum = x;
        t   = x;
        t = sq_step(t, x) / 64'd6;   sum = sum - t;
        t = sq_step(t, x) / 64'd20;  sum = sum + t;
        t = sq_step(t, x) / 64'd42;  sum = sum - t;
        t = sq_step(t, x) / 64'd72;  sum = sum + t;
        t = sq_step(t, x) / 64'd110; sum = sum - t;
        t = sq_step(t, x) / 64'd156; sum = sum + t;
        t = sq_step(t, x) / 64'd210; sum = sum - t;
        t = sq_step(t, x) / 64'd272; sum = sum + t;
        t = sq_step(t, x) / 64'd342; sum = sum - t;
        t = sq_step(t, x) / 64'd420; sum = sum + t;
        return sum;
    endfunction

    function automatic rom_t build_rom();
        rom_t        r;
        logic [63:0] base;
        logic [63:0] x;
        logic [63:0] s;
        logic [63:0] e;
        base = PI_Q60 >> (ROM_ADDR_BITS + 2);
        for (int i = 0; i < ROM_DEPTH; i++)
        begin
            x    = (base * (64'(2 * i) + 64'd1)) >> 30;
            s    = sine_q30(x);
            e    = (s * SINE_PEAK + (64'd1 << 29)) >> 30;
            r[i] = e[MAG_W-1:0];
        end
        return r;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    logic [MAG_W-1:0] mag_reg;
    logic             neg_reg;
    logic             before_reg;

    always_ff @(posedge clk)
    begin
        if (adv.rom_ld)
        begin
            mag_reg    <= SINE_ROM[rom_idx];
            neg_reg    <= negate_in;
            before_reg <= before_in;
        end
    end

    assign mag       = mag_reg;
    assign negate    = neg_reg;
    assign pre_delay = before_reg;

endmodule

// ===== rtl/dss_scale.sv =====
// ----------------------------------------------------------------------------
// dss_scale
// Amplitude multiply, round, bias add, saturation to 32 bits; zeros pre-delay.
// ----------------------------------------------------------------------------
module dss_scale #(
    parameter int SINE_BITS = 16
) (
    input  logic                       clk,
    input  dss_pkg::dss_adv_t          adv,
    input  dss_pkg::dss_cfg_t          cfg,
    input  logic [SINE_BITS-2:0]       mag,
    input  logic                       negate,
    input  logic                       before_in,
    output logic [dss_pkg::DATA_W-1:0] sample_out,
    output logic                       saturated
);
    import dss_pkg::*;

    localparam int K      = SINE_BITS - 1;
    localparam int PROD_W = DATA_W + SINE_BITS;
    localparam int SCL_W  = PROD_W - K;
    localparam int SUM_W  = SCL_W + 1;

    logic signed [SINE_BITS-1:0] sample;
    logic signed [PROD_W-1:0]    prod_reg;
    logic                        before_reg;
    logic signed [PROD_W-1:0]    rounded;
    logic signed [SCL_W-1:0]     scaled;
    logic signed [SUM_W-1:0]     sum;
    logic                        clip;
    logic [DATA_W-1:0]           value;
    logic [DATA_W-1:0]           sample_reg;
    logic                        sat_reg;

    assign sample = negate ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

    // round half up, then floor by arithmetic shift
    assign rounded = prod_reg + $signed(PROD_W'(1) <<< (K - 1));
    assign scaled  = SCL_W'(rounded >>> K);
    assign sum     = SUM_W'(scaled) + SUM_W'($signed(cfg.bias));
    assign clip    = (sum[SUM_W-1:DATA_W-1] != '0) && (sum[SUM_W-1:DATA_W-1] != '1);

    always_comb
    begin
        if (clip)
        begin
            value = sum[SUM_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        else
        begin
            value = sum[DATA_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv.scale_ld)
        begin
            prod_reg   <= PROD_W'($signed(cfg.amplitude)) * PROD_W'(sample);
            before_reg <= before_in;
        end
        if (adv.out_ld)
        begin
            sample_reg <= before_reg ? '0 : value;
            sat_reg    <= before_reg ? 1'b0 : clip;
        end
    end

    assign sample_out = sample_reg;
    assign saturated  = sat_reg;

endmodule

// ===== rtl/delayed_sine_source_top.sv =====
// ----------------------------------------------------------------------------
// delayed_sine_source_top
// Delayed sine source: time in, Q16.16 sine sample out, six-stage pipeline.
// ----------------------------------------------------------------------------
//  Channel   Handshake                    Payload
//  req       req_valid / req_ready        time_ticks
//  rsp       rsp_valid / rsp_ready        sample_out, saturated
//  cfg       cfg_we (no wait)             cfg_index, cfg_data
//
//  One word per cycle in and out while rsp_ready is high.
//  Stages: delay subtract, phase multiply, offset/quadrant, ROM read,
//  amplitude multiply, round/bias/saturate into the output register.
//  A stall at rsp squeezes bubbles out from the back; req_ready falls only
//  once all six stages hold a word. Reset clears valid bits and config but
//  sets amplitude to 1.0; the sine table is constant: no fill or clear pass.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module delayed_sine_source_top #(
    parameter int PHASE_BITS    = 32,
    parameter int ROM_ADDR_BITS = 10,
    parameter int SINE_BITS     = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  logic [dss_pkg::DATA_W-1:0]    time_ticks,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output logic [dss_pkg::DATA_W-1:0]    sample_out,
    output logic                          saturated,
    input  logic                          cfg_we,
    input  logic [dss_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [dss_pkg::DATA_W-1:0]    cfg_data
);
    import dss_pkg::*;

    // configuration registers
    dss_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.amplitude    <= AMPLITUDE_RESET;
            cfg_reg.phase_step   <= '0;
            cfg_reg.phase_offset <= '0;
            cfg_reg.bias         <= '0;
            cfg_reg.start_delay  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_AMPLITUDE:    cfg_reg.amplitude    <= cfg_data;
                CFG_PHASE_STEP:   cfg_reg.phase_step   <= cfg_data;
                CFG_PHASE_OFFSET: cfg_reg.phase_offset <= cfg_data;
                CFG_BIAS:         cfg_reg.bias         <= cfg_data;
                CFG_START_DELAY:  cfg_reg.start_delay  <= cfg_data;
                default:          ;  // unknown index: dropped
            endcase
        end
    end

    // pipeline valid bits; stage NUM_STAGES-1 is the output register
    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] stage_ready;
    logic [NUM_STAGES-1:0] valid_in;
    dss_adv_t              adv;

    assign valid_in = {valid_reg[NUM_STAGES-2:0], req_valid};

    // a stage loads when empty or when its word moves on
    always_comb
    begin
        stage_ready[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || rsp_ready;
        for (int i = NUM_STAGES - 2; i >= 0; i--)
        begin
            stage_ready[i] = !valid_reg[i] || stage_ready[i+1];
        end
        for (int i = 0; i < NUM_STAGES; i++)
        begin
            valid_next[i] = stage_ready[i] ? valid_in[i] : valid_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign adv.diff_ld  = stage_ready[0];
    assign adv.mul_ld   = stage_ready[1];
    assign adv.phase_ld = stage_ready[2];
    assign adv.rom_ld   = stage_ready[3];
    assign adv.scale_ld = stage_ready[4];
    assign adv.out_ld   = stage_ready[5];

    assign req_ready = stage_ready[0];
    assign rsp_valid = valid_reg[NUM_STAGES-1];

    // datapath
    logic [ROM_ADDR_BITS-1:0] rom_idx;
    logic                     ph_neg;
    logic                     ph_before;
    logic [SINE_BITS-2:0]     rom_mag;
    logic                     rom_neg;
    logic                     rom_before;

    dss_phase #(
        .PHASE_BITS    (PHASE_BITS),
        .ROM_ADDR_BITS (ROM_ADDR_BITS)
    ) u_phase (
        .clk        (clk),
        .adv        (adv),
        .cfg        (cfg_reg),
        .time_ticks (time_ticks),
        .rom_idx    (rom_idx),
        .negate     (ph_neg),
        .pre_delay  (ph_before)
    );

    dss_rom #(
        .ROM_ADDR_BITS (ROM_ADDR_BITS),
        .SINE_BITS     (SINE_BITS)
    ) u_rom (
        .clk       (clk),
        .adv       (adv),
        .rom_idx   (rom_idx),
        .negate_in (ph_neg),
        .before_in (ph_before),
        .mag       (rom_mag),
        .negate    (rom_neg),
        .pre_delay (rom_before)
    );

    dss_scale #(
        .SINE_BITS (SINE_BITS)
    ) u_scale (
        .clk        (clk),
        .adv        (adv),
        .cfg        (cfg_reg),
        .mag        (rom_mag),
        .negate     (rom_neg),
        .before_in  (rom_before),
        .sample_out (sample_out),
        .saturated  (saturated)
    );

    // full pipeline with a stalled output must push back on req
    `DSS_ASSERT_IMP(a_full_backpressure, clk, rst_n, (&valid_reg) && !rsp_ready, !req_ready)
    // an accepted word lands in the first stage
    `DSS_ASSERT_NXT(a_accept_lands, clk, rst_n, req_valid && req_ready, valid_reg[0])
    // a clipped word sits at one of the rails
    `DSS_ASSERT_IMP(a_sat_rail, clk, rst_n, rsp_valid && saturated,
        (sample_out == 32'h7FFF_FFFF) || (sample_out == 32'h8000_0000))

endmodule
